### rtl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

  localparam int BUTTON_COUNT = 3;
  localparam int LANES = 3;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd400;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [LANES-1:0]  raw_levels;
  } in_t;

  typedef struct packed {
    logic [LANES-1:0]  pressed_mask;
    logic [LANES-1:0]  click_mask;
    logic [LANES-1:0]  long_press_mask;
    logic [LANES-1:0]  double_click_mask;
    logic [TIME_W-1:0] hold_time_a;
    logic [TIME_W-1:0] hold_time_b;
    logic [TIME_W-1:0] hold_time_c;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
  } cfg_t;

  typedef struct packed {
    logic              pressed;
    logic              click;
    logic              long_press;
    logic              double_click;
    logic [TIME_W-1:0] hold;
  } lane_res_t;

endpackage

### rtl/bdpc_lane.sv
`timescale 1ns / 1ps

module bdpc_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [bdpc_pkg::TIME_W-1:0] now_ms,
  input  logic                      raw,
  input  bdpc_pkg::cfg_t            cfg,
  output bdpc_pkg::lane_res_t       res
);
  import bdpc_pkg::*;

  logic              prior_raw;
  logic [TIME_W-1:0] bounce_start;
  logic              stable_level;
  logic [TIME_W-1:0] press_start;
  logic [TIME_W-1:0] previous_press_time;

  logic              changed;
  logic              settle;
  logic              rise;
  logic              fall;
  logic [TIME_W-1:0] since_bounce;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_prev;
  logic              short_hold;

  always_comb begin
    changed      = raw != prior_raw;
    since_bounce = now_ms - bounce_start;
    since_press  = now_ms - press_start;
    since_prev   = now_ms - previous_press_time;
    settle       = !changed && (since_bounce > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
    rise         = settle && raw && !stable_level;
    fall         = settle && !raw && stable_level;
    short_hold   = since_press < {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};

    res.pressed      = settle ? raw : stable_level;
    res.click        = fall && short_hold;
    res.long_press   = fall && !short_hold;
    res.double_click = rise &&
                       (since_prev < {{(TIME_W-CFG_W){1'b0}}, cfg.double_click_ms});
    if (!res.pressed || rise) begin
      res.hold = '0;
    end else begin
      res.hold = since_press;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_raw           <= 1'b0;
      bounce_start        <= '0;
      stable_level        <= 1'b0;
      press_start         <= '0;
      previous_press_time <= '0;
    end else if (advance) begin
      prior_raw <= raw;
      if (changed) begin
        bounce_start <= now_ms;
      end
      if (settle) begin
        stable_level <= raw;
      end
      if (rise) begin
        press_start         <= now_ms;
        previous_press_time <= now_ms;
      end
    end
  end

endmodule

### rtl/bdpc_merge.sv
`timescale 1ns / 1ps

module bdpc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  bdpc_pkg::lane_res_t lane_res [bdpc_pkg::LANES],
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bdpc_pkg::out_t      out_data
);
  import bdpc_pkg::*;

  out_t merged;
  out_t skid_data;
  logic skid_valid;

  always_comb begin
    merged = '0;
    for (int i = 0; i < LANES; i++) begin
      merged.pressed_mask[i]      = lane_res[i].pressed;
      merged.click_mask[i]        = lane_res[i].click;
      merged.long_press_mask[i]   = lane_res[i].long_press;
      merged.double_click_mask[i] = lane_res[i].double_click;
    end
    merged.hold_time_a = lane_res[0].hold;
    merged.hold_time_b = lane_res[1].hold;
    merged.hold_time_c = lane_res[2].hold;
  end

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (load) begin
        out_data  <= merged;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (load) begin
      // hold the new beat while the output is stalled
      skid_data  <= merged;
      skid_valid <= 1'b1;
    end
  end

endmodule

### rtl/button_debounce_press_classifier_top.sv
`timescale 1ns / 1ps
// Button debounce and press classifier for three buttons.
// Input channel (in_valid/in_ready/in_data): one beat per sample, carrying a
// millisecond timestamp and the raw level of each button.
// Output channel (out_valid/out_ready/out_data): one beat per input beat, in
// order, with debounced levels, one-shot click, long-press and double-click
// bits, and the running hold time of each pressed button.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes debounce,
// long-press and double-click thresholds; cfg_ready is always high and
// unknown indexes are dropped. Write only while no beat is in flight.
// Result: each accepted sample is registered in the output or skid register.
// Throughput: one sample per cycle while in_ready is high; each button lane
// settles its state with parallel subtract and compare logic.
// Stall: a two-entry output stage (output register plus skid register)
// absorbs one extra beat; in_ready drops only when both are full.
// Reset: synchronous rst clears all button state, restores the default
// thresholds (50, 1000, 400) and empties the output stage.
module button_debounce_press_classifier_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bdpc_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bdpc_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdpc_pkg::CFG_W-1:0]         cfg_data
);
  import bdpc_pkg::*;

  cfg_t      cfg;
  logic      accept;
  lane_res_t lane_res [LANES];

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RESET;
      cfg.long_press_ms   <= LONG_PRESS_RESET;
      cfg.double_click_ms <= DOUBLE_CLICK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < BUTTON_COUNT) begin : g_on
      bdpc_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .advance (accept),
        .now_ms  (in_data.now_ms),
        .raw     (in_data.raw_levels[i]),
        .cfg     (cfg),
        .res     (lane_res[i])
      );
    end else begin : g_off
      assign lane_res[i] = '0;
    end
  end

  bdpc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .lane_res  (lane_res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/bdpc_checker.sv
`timescale 1ns / 1ps

module bdpc_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input bdpc_pkg::out_t out_data
);
  import bdpc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_release_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.click_mask & out_data.long_press_mask) == '0) &&
                  (((out_data.click_mask | out_data.long_press_mask) &
                    out_data.pressed_mask) == '0))
    else $error("release event on a pressed button or both kinds at once");

  a_double_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.double_click_mask & ~out_data.pressed_mask) == '0))
    else $error("double click on a released button");

  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pressed_mask[0] |-> out_data.hold_time_a == '0)
    else $error("hold time on a released button");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
